FILE: rtl/core/ssa_pkg.sv
`timescale 1ns / 1ps
// ssa_pkg: shared types, codes and default sizes for the segment sum accumulator.
// No dependencies; imported by segment_sum_accumulator.

package ssa_pkg;

	// default store geometry
	localparam int OUTER_MAX_DEF    = 4;
	localparam int SEGMENTS_MAX_DEF = 256;
	localparam int INNER_MAX_DEF    = 16;

	// item kinds
	localparam logic [1:0] KIND_ACC   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_NEG  = 2'd2;

	// configuration register indexes
	localparam int         CFG_IDX_W          = 4;
	localparam logic [3:0] CFG_SEGMENT_COUNT  = 4'd0;
	localparam logic [3:0] CFG_SEGMENT_OFFSET = 4'd1;
	localparam int         CFG_DATA_W         = 32;

	localparam int SEG_COUNT_W  = 9;
	localparam int SEG_OFFSET_W = 31;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] segment_id;
		logic [1:0]         outer_pos;
		logic [3:0]         inner_pos;
		logic signed [31:0] value;
		logic               last_item;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] slot_sum;
		logic               last_out;
	} out_item_t;

endpackage

FILE: rtl/core/ssa_ram.sv
`timescale 1ns / 1ps
// ssa_ram: generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.

module ssa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/segment_sum_accumulator.sv
`timescale 1ns / 1ps
// segment_sum_accumulator: top level of the scatter-add engine.
// Depends on ssa_pkg and ssa_ram.

// Scatter-add (unsorted segment sum) engine over a Q16.16 accumulator store
// of OUTER_MAX*SEGMENTS_MAX*INNER_MAX words held in one synchronous RAM.
// Each item is accumulate, read or clear of one slot; every item returns
// exactly one result item with a status (done, skipped, negative id), the
// slot contents after the operation (0 unless done) and the batch marker.
// Throughput is one item per clock unless result_stall or the reset sweep
// holds the flow: decode at accept, RAM read in stage 1, read-modify-write
// in stage 2, then an output register. A back-to-back hit on the same
// slot is served by forwarding the last written word. After reset the store
// is swept to zero one word per cycle, all SLOTS words (16384 at the default
// sizes); item_stall stays high for that whole sweep. Configuration writes
// are always taken (cfg_ready is tied high) and must only be issued while
// no item is in flight.

module segment_sum_accumulator #(
	parameter int OUTER_MAX    = ssa_pkg::OUTER_MAX_DEF,
	parameter int SEGMENTS_MAX = ssa_pkg::SEGMENTS_MAX_DEF,
	parameter int INNER_MAX    = ssa_pkg::INNER_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  ssa_pkg::in_item_t             item,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output ssa_pkg::out_item_t            result,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_data
);

	import ssa_pkg::*;

	localparam int SLOTS = OUTER_MAX * SEGMENTS_MAX * INNER_MAX;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// configuration registers
	logic [SEG_COUNT_W-1:0]  seg_count_q;
	logic [SEG_OFFSET_W-1:0] seg_offset_q;

	// reset sweep
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// stage 1: decoded item, RAM read in flight
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic          hit_s1;
	logic [1:0]    status_s1;
	logic [1:0]    kind_s1;
	logic [31:0]   value_s1;
	logic          last_s1;

	// stage 2: RAM data present, modify and write back
	logic          valid_s2;
	logic [AW-1:0] addr_s2;
	logic          hit_s2;
	logic [1:0]    status_s2;
	logic [1:0]    kind_s2;
	logic [31:0]   value_s2;
	logic          last_s2;

	// last item write, for forwarding
	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [31:0]   wr_data_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	logic        s2_adv, s1_adv, accept;
	logic [31:0] diff;
	logic        seg_ok, pos_ok, kind_ok, in_hit;
	logic [1:0]  in_status;
	logic [31:0] slot_full;
	logic [31:0] ram_rdata, cur_s2, new_s2;
	logic        item_wr;
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;

	// ---------------- handshake ----------------
	assign s2_adv     = valid_s2 && (!out_valid_q || !result_stall);
	assign s1_adv     = valid_s1 && (!valid_s2 || s2_adv);
	assign item_stall = clearing_q || (valid_s1 && !s1_adv);
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ---------------- decode at accept ----------------
	// non-negative id minus offset; bit 31 set means the shifted id went negative
	assign diff = {1'b0, item.segment_id[30:0]} - {1'b0, seg_offset_q};

	assign seg_ok  = !diff[31] && (diff < {{(32-SEG_COUNT_W){1'b0}}, seg_count_q})
		&& (diff < 32'(SEGMENTS_MAX));
	assign pos_ok  = (32'(item.outer_pos) < 32'(OUTER_MAX))
		&& (32'(item.inner_pos) < 32'(INNER_MAX));
	assign kind_ok = (item.kind == KIND_ACC) || (item.kind == KIND_READ)
		|| (item.kind == KIND_CLEAR);
	assign in_hit  = !item.segment_id[31] && seg_ok && pos_ok && kind_ok;

	always_comb begin
		priority if (item.segment_id[31]) begin
			in_status = ST_NEG;
		end else if (in_hit) begin
			in_status = ST_DONE;
		end else begin
			in_status = ST_SKIP;
		end
	end

	// (outer*SEGMENTS_MAX + segment)*INNER_MAX + inner; constant multipliers
	assign slot_full = (32'(item.outer_pos) * 32'(SEGMENTS_MAX) + diff) * 32'(INNER_MAX)
		+ 32'(item.inner_pos);

	// ---------------- stage 2 modify ----------------
	assign cur_s2 = (wr_vld_q && (wr_addr_q == addr_s2)) ? wr_data_q : ram_rdata;

	always_comb begin
		unique case (kind_s2)
			KIND_ACC:   new_s2 = cur_s2 + value_s2;   // wraps mod 2^32
			KIND_CLEAR: new_s2 = '0;
			default:    new_s2 = cur_s2;
		endcase
	end

	assign item_wr = s2_adv && hit_s2 && (kind_s2 != KIND_READ);

	// write port: reset sweep owns it until done, no items run meanwhile
	assign ram_we    = clearing_q || item_wr;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clearing_q ? '0 : new_s2;

	ssa_ram #(
		.WIDTH (32),
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (s1_adv),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q  <= SEG_COUNT_W'(256);
			seg_offset_q <= '0;
			clearing_q   <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			wr_vld_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SEGMENT_COUNT) begin
					seg_count_q <= cfg_data[SEG_COUNT_W-1:0];
				end else if (cfg_index == CFG_SEGMENT_OFFSET) begin
					seg_offset_q <= cfg_data[SEG_OFFSET_W-1:0];
				end
			end
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(SLOTS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (item_wr) begin
				wr_vld_q <= 1'b1;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= slot_full[AW-1:0];
			hit_s1    <= in_hit;
			status_s1 <= in_status;
			kind_s1   <= item.kind;
			value_s1  <= item.value;
			last_s1   <= item.last_item;
		end
		if (s1_adv) begin
			addr_s2   <= addr_s1;
			hit_s2    <= hit_s1;
			status_s2 <= status_s1;
			kind_s2   <= kind_s1;
			value_s2  <= value_s1;
			last_s2   <= last_s1;
		end
		if (item_wr) begin
			wr_addr_q <= addr_s2;
			wr_data_q <= new_s2;
		end
		if (s2_adv) begin
			out_q.status   <= status_s2;
			out_q.slot_sum <= hit_s2 ? new_s2 : '0;
			out_q.last_out <= last_s2;
		end
	end

endmodule
